>>> rtl/mi3_pkg.sv
`timescale 1ns / 1ps
// shared widths, constants, index tables and types for the 3x3 matrix inverse
// no dependencies; used by every module of the block
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int N         = 9;
  localparam int ELEM_W    = 32;
  localparam int HALF_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ADJ_W     = 2 * ELEM_W;
  localparam int DMAG_W    = ELEM_W + ADJ_W;
  localparam int DET_W     = DMAG_W + 1;
  localparam int QUOT_W    = 32;
  localparam int NUM_W     = ADJ_W + 2 * FRAC_BITS;
  localparam int DIV_W     = DMAG_W + QUOT_W;
  localparam int THR_W     = 17;
  localparam int DATA_W    = N * ELEM_W;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ADJ_W-1:0]         adj_mag_t;
  typedef logic [3:0]               idx_t;
  typedef logic [1:0]               row_idx_t;

  // cofactor k = sign * (m[PA]*m[PB] - m[PC]*m[PD]), flat row-major index
  localparam idx_t PA [N] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
  localparam idx_t PB [N] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
  localparam idx_t PC [N] = '{4'd5, 4'd2, 4'd2, 4'd5, 4'd2, 4'd2, 4'd4, 4'd1, 4'd1};
  localparam idx_t PD [N] = '{4'd7, 4'd7, 4'd4, 4'd6, 4'd6, 4'd3, 4'd6, 4'd6, 4'd3};
  localparam logic [N-1:0] ADJ_NEG = 9'b010101010;

  // adjugate entries paired with the first row for the determinant
  localparam idx_t DET_ADJ [3] = '{4'd0, 4'd3, 4'd6};

  // diagonal positions of the identity result
  localparam logic [N-1:0] DIAG = 9'b100010001;

  localparam logic [ELEM_W-1:0] ONE_FIXED = ELEM_W'(1) << FRAC_BITS;
  localparam logic [ELEM_W-1:0] SAT_POS   = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_NEG   = {1'b1, {(ELEM_W-1){1'b0}}};

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  // per-item decisions carried alongside the divider
  typedef struct packed {
    logic         singular;
    logic [N-1:0] neg;
    logic [N-1:0] ovf;
  } mi3_flags_t;

endpackage

>>> rtl/mi3_cofactor.sv
`timescale 1ns / 1ps
// input register, 2x2 minor products and adjugate in sign-magnitude form
// depends on mi3_pkg
module mi3_cofactor (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  mi3_pkg::elem_t           in_m [mi3_pkg::N],
  output logic                     out_valid,
  output mi3_pkg::adj_mag_t        adj_mag [mi3_pkg::N],
  output logic [mi3_pkg::N-1:0]    adj_neg,
  output logic [mi3_pkg::ELEM_W-1:0] r0_mag [3],
  output logic [2:0]               r0_neg
);

  logic           v1, v2, v3;
  mi3_pkg::elem_t m1 [mi3_pkg::N];
  mi3_pkg::prod_t pl [mi3_pkg::N];
  mi3_pkg::prod_t pr [mi3_pkg::N];
  mi3_pkg::elem_t r0_2 [3];
  mi3_pkg::prod_t adj [mi3_pkg::N];
  mi3_pkg::elem_t r0_3 [3];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= in_m;
    end
  end

  // stage 2: two products per cofactor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N; k++) begin
        pl[k] <= m1[mi3_pkg::PA[k]] * m1[mi3_pkg::PB[k]];
        pr[k] <= m1[mi3_pkg::PC[k]] * m1[mi3_pkg::PD[k]];
      end
      for (int j = 0; j < 3; j++) begin
        r0_2[j] <= m1[j];
      end
    end
  end

  // stage 3: signed cofactor, exact in 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N; k++) begin
        adj[k] <= mi3_pkg::ADJ_NEG[k] ? (pr[k] - pl[k]) : (pl[k] - pr[k]);
      end
      r0_3 <= r0_2;
    end
  end

  // stage 4: magnitudes and signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < mi3_pkg::N; k++) begin
        adj_neg[k] <= adj[k][mi3_pkg::ADJ_W-1];
        adj_mag[k] <= adj[k][mi3_pkg::ADJ_W-1] ? mi3_pkg::ADJ_W'(-adj[k])
                                                : mi3_pkg::ADJ_W'(adj[k]);
      end
      for (int j = 0; j < 3; j++) begin
        r0_neg[j] <= r0_3[j][mi3_pkg::ELEM_W-1];
        r0_mag[j] <= r0_3[j][mi3_pkg::ELEM_W-1] ? mi3_pkg::ELEM_W'(-r0_3[j])
                                                 : mi3_pkg::ELEM_W'(r0_3[j]);
      end
    end
  end

endmodule

>>> rtl/mi3_det.sv
`timescale 1ns / 1ps
// determinant by first-row expansion, singular test, overflow test, numerators
// depends on mi3_pkg
module mi3_det (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [mi3_pkg::THR_W-1:0]  thr,
  input  logic                       in_valid,
  input  mi3_pkg::adj_mag_t          adj_mag [mi3_pkg::N],
  input  logic [mi3_pkg::N-1:0]      adj_neg,
  input  logic [mi3_pkg::ELEM_W-1:0] r0_mag [3],
  input  logic [2:0]                 r0_neg,
  output logic                       out_valid,
  output mi3_pkg::mi3_flags_t        flags,
  output logic [mi3_pkg::DMAG_W-1:0] dmag,
  output logic [mi3_pkg::NUM_W-1:0]  num [mi3_pkg::N]
);

  logic v5, v6, v7, v8;
  logic [mi3_pkg::PROD_W-1:0] plo [3];
  logic [mi3_pkg::PROD_W-1:0] phi [3];
  logic [2:0]                 tsign;
  logic [mi3_pkg::DET_W-1:0]  term [3];
  logic [mi3_pkg::DET_W-1:0]  det;
  logic [mi3_pkg::DET_W-1:0]  det_abs;
  logic                       dneg8;
  logic [mi3_pkg::DMAG_W-1:0] dmag8;
  mi3_pkg::adj_mag_t          am5 [mi3_pkg::N];
  mi3_pkg::adj_mag_t          am6 [mi3_pkg::N];
  mi3_pkg::adj_mag_t          am7 [mi3_pkg::N];
  mi3_pkg::adj_mag_t          am8 [mi3_pkg::N];
  logic [mi3_pkg::N-1:0]      an5, an6, an7, an8;
  logic [mi3_pkg::DMAG_W-1:0] thr_sh;
  logic [mi3_pkg::DIV_W-1:0]  dmag_top;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      out_valid <= v8;
    end
  end

  // stage 5: 32x32 partial products of first row by adjugate halves
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo[j]   <= r0_mag[j] * adj_mag[mi3_pkg::DET_ADJ[j]][mi3_pkg::HALF_W-1:0];
        phi[j]   <= r0_mag[j] * adj_mag[mi3_pkg::DET_ADJ[j]][mi3_pkg::ADJ_W-1:mi3_pkg::HALF_W];
        tsign[j] <= r0_neg[j] ^ adj_neg[mi3_pkg::DET_ADJ[j]];
      end
      am5 <= adj_mag;
      an5 <= adj_neg;
    end
  end

  // stage 6: combine partial products into signed terms
  always_ff @(posedge clk) begin
    logic [mi3_pkg::DET_W-1:0] ext;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        ext = {1'b0, (mi3_pkg::DMAG_W'(phi[j]) << mi3_pkg::HALF_W)
                     + mi3_pkg::DMAG_W'(plo[j])};
        term[j] <= tsign[j] ? (~ext + 1'b1) : ext;
      end
      am6 <= am5;
      an6 <= an5;
    end
  end

  // stage 7: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det <= term[0] + term[1] + term[2];
      am7 <= am6;
      an7 <= an6;
    end
  end

  // stage 8: determinant magnitude and sign
  assign det_abs = det[mi3_pkg::DET_W-1] ? (~det + 1'b1) : det;

  always_ff @(posedge clk) begin
    if (en) begin
      dneg8 <= det[mi3_pkg::DET_W-1];
      dmag8 <= det_abs[mi3_pkg::DMAG_W-1:0];
      am8   <= am7;
      an8   <= an7;
    end
  end

  // stage 9: singular and overflow decisions, divider numerators
  assign thr_sh   = mi3_pkg::DMAG_W'(thr) << (2 * mi3_pkg::FRAC_BITS);
  assign dmag_top = mi3_pkg::DIV_W'(dmag8) << mi3_pkg::QUOT_W;

  always_ff @(posedge clk) begin
    if (en) begin
      flags.singular <= (dmag8 == '0) || (dmag8 < thr_sh);
      for (int k = 0; k < mi3_pkg::N; k++) begin
        flags.neg[k] <= an8[k] ^ dneg8;
        flags.ovf[k] <= (mi3_pkg::DIV_W'(am8[k]) << (2 * mi3_pkg::FRAC_BITS)) >= dmag_top;
        num[k]       <= mi3_pkg::NUM_W'(am8[k]) << (2 * mi3_pkg::FRAC_BITS);
      end
      dmag <= dmag8;
    end
  end

endmodule

>>> rtl/mi3_divider.sv
`timescale 1ns / 1ps
// nine-lane restoring divider, one quotient bit per stage, and output stage
// depends on mi3_pkg
module mi3_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  mi3_pkg::mi3_flags_t        in_flags,
  input  logic [mi3_pkg::DMAG_W-1:0] in_dmag,
  input  logic [mi3_pkg::NUM_W-1:0]  in_num [mi3_pkg::N],
  output logic                       out_valid,
  output logic [mi3_pkg::ELEM_W-1:0] out_inv [mi3_pkg::N],
  output logic                       out_singular
);

  localparam int S = mi3_pkg::QUOT_W;

  logic [mi3_pkg::DIV_W-1:0]  stg_rem [S][mi3_pkg::N];
  logic [mi3_pkg::QUOT_W-1:0] stg_quo [S][mi3_pkg::N];
  logic [mi3_pkg::DMAG_W-1:0] stg_dmag [S];
  mi3_pkg::mi3_flags_t        stg_flags [S];
  logic [S-1:0]               stg_vld;

  logic [mi3_pkg::DIV_W-1:0]  rem_next [S][mi3_pkg::N];
  logic [mi3_pkg::QUOT_W-1:0] quo_next [S][mi3_pkg::N];

  logic [mi3_pkg::DIV_W-1:0]  rem [S][mi3_pkg::N];
  logic [mi3_pkg::QUOT_W-1:0] quo [S][mi3_pkg::N];
  logic [mi3_pkg::DMAG_W-1:0] dmag_r [S];
  mi3_pkg::mi3_flags_t        flags_r [S];
  logic [S-1:0]               vld;

  // stage inputs: first step from the ports, others from the step before
  always_comb begin
    for (int k = 0; k < mi3_pkg::N; k++) begin
      stg_rem[0][k] = mi3_pkg::DIV_W'(in_num[k]);
      stg_quo[0][k] = '0;
    end
    stg_dmag[0]  = in_dmag;
    stg_flags[0] = in_flags;
    stg_vld[0]   = in_valid;
    for (int s = 1; s < S; s++) begin
      stg_rem[s]   = rem[s-1];
      stg_quo[s]   = quo[s-1];
      stg_dmag[s]  = dmag_r[s-1];
      stg_flags[s] = flags_r[s-1];
      stg_vld[s]   = vld[s-1];
    end
  end

  // one compare and subtract per step, quotient bit from msb down
  always_comb begin
    logic [mi3_pkg::DIV_W-1:0] dsh;
    for (int s = 0; s < S; s++) begin
      dsh = mi3_pkg::DIV_W'(stg_dmag[s]) << (S - 1 - s);
      for (int k = 0; k < mi3_pkg::N; k++) begin
        if (stg_rem[s][k] >= dsh) begin
          rem_next[s][k] = stg_rem[s][k] - dsh;
          quo_next[s][k] = stg_quo[s][k] | (mi3_pkg::QUOT_W'(1) << (S - 1 - s));
        end else begin
          rem_next[s][k] = stg_rem[s][k];
          quo_next[s][k] = stg_quo[s][k];
        end
      end
    end
  end

  // step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= stg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem     <= rem_next;
      quo     <= quo_next;
      dmag_r  <= stg_dmag;
      flags_r <= stg_flags;
    end
  end

  // output stage: identity, saturation or signed quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[S-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [mi3_pkg::QUOT_W-1:0] q;
    if (en) begin
      out_singular <= flags_r[S-1].singular;
      for (int k = 0; k < mi3_pkg::N; k++) begin
        q = quo[S-1][k];
        if (flags_r[S-1].singular) begin
          out_inv[k] <= mi3_pkg::DIAG[k] ? mi3_pkg::ONE_FIXED : '0;
        end else if (!flags_r[S-1].neg[k]) begin
          out_inv[k] <= (flags_r[S-1].ovf[k] || q > mi3_pkg::SAT_POS) ? mi3_pkg::SAT_POS : q;
        end else begin
          out_inv[k] <= (flags_r[S-1].ovf[k] || q > mi3_pkg::SAT_NEG) ? mi3_pkg::SAT_NEG
                                                                     : (~q + 1'b1);
        end
      end
    end
  end

endmodule

>>> rtl/matrix3x3_inverse_core.sv
`timescale 1ns / 1ps
// 3x3 fixed-point matrix inverse by adjugate over determinant
// pipeline from input accept to output valid: 4 cofactor stages,
// 5 determinant stages, 32 divider steps (one quotient bit each), 1 output stage
// throughput one matrix per cycle; a stalled output holds the whole pipeline
// rst (synchronous) empties the pipeline and sets singular_threshold to 1
// depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_divider
module matrix3x3_inverse_core (
  input  logic                       clk,
  input  logic                       rst,
  // configuration: singular_threshold
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mi3_pkg::THR_W-1:0]  cfg_data,
  // input matrix
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mi3_pkg::DATA_W-1:0] s_tdata,  // a00, a01, a02, a10, a11, a12, a20, a21, a22
  // result matrix
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mi3_pkg::DATA_W-1:0] m_tdata,  // inv00, inv01, inv02, ... inv22
  output logic [0:0]                 m_tuser   // singular
);

  logic                         en;
  logic [mi3_pkg::THR_W-1:0]    thr;
  mi3_pkg::elem_t               in_m [mi3_pkg::N];
  logic                         c_valid;
  mi3_pkg::adj_mag_t            c_adj_mag [mi3_pkg::N];
  logic [mi3_pkg::N-1:0]        c_adj_neg;
  logic [mi3_pkg::ELEM_W-1:0]   c_r0_mag [3];
  logic [2:0]                   c_r0_neg;
  logic                         d_valid;
  mi3_pkg::mi3_flags_t          d_flags;
  logic [mi3_pkg::DMAG_W-1:0]   d_dmag;
  logic [mi3_pkg::NUM_W-1:0]    d_num [mi3_pkg::N];
  logic [mi3_pkg::ELEM_W-1:0]   inv [mi3_pkg::N];
  logic                         singular;

  // whole pipeline advances unless a result is stuck at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // threshold register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= mi3_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  // unpack input matrix
  always_comb begin
    for (int k = 0; k < mi3_pkg::N; k++) begin
      in_m[k] = s_tdata[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W];
    end
  end

  mi3_cofactor u_cofactor (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid && s_tready),
    .in_m      (in_m),
    .out_valid (c_valid),
    .adj_mag   (c_adj_mag),
    .adj_neg   (c_adj_neg),
    .r0_mag    (c_r0_mag),
    .r0_neg    (c_r0_neg)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .thr       (thr),
    .in_valid  (c_valid),
    .adj_mag   (c_adj_mag),
    .adj_neg   (c_adj_neg),
    .r0_mag    (c_r0_mag),
    .r0_neg    (c_r0_neg),
    .out_valid (d_valid),
    .flags     (d_flags),
    .dmag      (d_dmag),
    .num       (d_num)
  );

  mi3_divider u_divider (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (d_valid),
    .in_flags     (d_flags),
    .in_dmag      (d_dmag),
    .in_num       (d_num),
    .out_valid    (m_tvalid),
    .out_inv      (inv),
    .out_singular (singular)
  );

  // pack result
  always_comb begin
    for (int k = 0; k < mi3_pkg::N; k++) begin
      m_tdata[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] = inv[k];
    end
  end

  assign m_tuser = singular;

endmodule

>>> rtl/mi3_checker.sv
`timescale 1ns / 1ps
// port-level checks for the matrix inverse core, attached by bind
// depends on mi3_pkg and matrix3x3_inverse_core
module mi3_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [mi3_pkg::DATA_W-1:0] m_tdata,
  input logic [0:0]                 m_tuser
);

  logic [mi3_pkg::DATA_W-1:0] ident;

  // identity matrix as it appears on the output bus
  always_comb begin
    for (int k = 0; k < mi3_pkg::N; k++) begin
      ident[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W] =
        mi3_pkg::DIAG[k] ? mi3_pkg::ONE_FIXED : '0;
    end
  end

  // stalled result stays and holds its data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // singular results carry the identity
  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == ident)
    else $error("singular result is not the identity");

  // input is taken exactly when the output can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output state");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (.*);
